[rtl/core/key_event_queue_with_escape_interrupt_defines.svh]
// Assertion macros used by the key event queue RTL.
`ifndef KEY_EVENT_QUEUE_WITH_ESCAPE_INTERRUPT_DEFINES_SVH
`define KEY_EVENT_QUEUE_WITH_ESCAPE_INTERRUPT_DEFINES_SVH

`ifndef SYNTHESIS
`define KEVQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kevq assertion failed");
`define KEVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kevq assertion failed");
`else
`define KEVQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KEVQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/kevq_pkg.sv]
package kevq_pkg;

    localparam logic [2:0] CMD_KEY   = 3'd0;
    localparam logic [2:0] CMD_POP   = 3'd1;
    localparam logic [2:0] CMD_CAP   = 3'd2;
    localparam logic [2:0] CMD_POLL  = 3'd3;
    localparam logic [2:0] CMD_BEGIN = 3'd4;
    localparam logic [2:0] CMD_END   = 3'd5;

    localparam logic [2:0] REG_ESCAPE    = 3'd0;
    localparam logic [2:0] REG_ENTER     = 3'd1;
    localparam logic [2:0] REG_BACKSPACE = 3'd2;
    localparam logic [2:0] REG_TAB       = 3'd3;
    localparam logic [2:0] REG_DELETE    = 3'd4;
    localparam logic [2:0] REG_POLL_INT  = 3'd5;
    localparam logic [2:0] REG_FORCE_QT  = 3'd6;

    localparam logic [7:0]  RST_ESCAPE    = 8'd27;
    localparam logic [7:0]  RST_ENTER     = 8'd13;
    localparam logic [7:0]  RST_BACKSPACE = 8'd8;
    localparam logic [7:0]  RST_TAB       = 8'd9;
    localparam logic [7:0]  RST_DELETE    = 8'd127;
    localparam logic [15:0] RST_POLL_INT  = 16'd20;
    localparam logic [7:0]  RST_FORCE_QT  = 8'd2;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_BS  = 8'd8;
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_DEL = 8'd127;

    localparam logic [7:0] ESC_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] ch;
        logic       shift;
        logic       ctrl;
        logic       alt;
    } kevq_entry_t;

    localparam int ENTRY_W = $bits(kevq_entry_t);

endpackage

[rtl/core/kevq_ram.sv]
module kevq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/key_event_queue_with_escape_interrupt.sv]
// Keyboard event queue with an escape interrupt. Each input beat carries one command: key
// event, pop, set capture, poll tick, begin run or end run; each gives exactly one result
// beat, in order. Pressed keys are stored in a ring of QUEUE_DEPTH entries that drops the
// oldest entry when full; enter, backspace, tab and delete codes (set through the
// configuration port) are mapped to CR, BS, TAB and DEL. With capture off the escape key
// only sets a flag; with capture on it is queued and counted. A run's poll tick at least
// poll_interval_ms past the last effective poll latches the interrupt if escape was seen or
// its count reached the force threshold. A beat is taken each cycle unless output stalls;
// a result passes stage one (registered store read) and the output register. Configuration
// writes apply at once, unchecked; the user must make them only while no beat is in flight.
`include "key_event_queue_with_escape_interrupt_defines.svh"

module key_event_queue_with_escape_interrupt
    import kevq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [2:0]                         cfg_index,
    input  logic [15:0]                        cfg_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_command,
    input  logic [7:0]                         s_key_code,
    input  logic [7:0]                         s_key_char,
    input  logic                               s_shift,
    input  logic                               s_ctrl,
    input  logic                               s_alt,
    input  logic                               s_pressed,
    input  logic                               s_capture_on,
    input  logic [31:0]                        s_now_ms,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_event_valid,
    output logic [7:0]                         m_out_code,
    output logic [7:0]                         m_out_char,
    output logic                               m_out_shift,
    output logic                               m_out_ctrl,
    output logic                               m_out_alt,
    output logic                               m_interrupt,
    output logic                               m_previous_capture,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   m_queued_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    logic [7:0]  esc_key_reg, enter_key_reg, bs_key_reg, tab_key_reg, del_key_reg;
    logic [15:0] poll_int_reg;
    logic [7:0]  fq_reg;

    logic [PTR_W-1:0] rp_reg, rp_next, rp_inc;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             esc_seen_reg, esc_seen_next;
    logic             cap_reg, cap_next;
    logic [7:0]       uc_reg, uc_next, uc_eff;
    logic             run_reg, run_next;
    logic             intr_reg, intr_next;
    logic [31:0]      last_reg, last_next;

    logic             s1_valid_reg, s1_pop_reg, s1_intr_reg, s1_prev_reg;
    logic [CNT_W-1:0] s1_cnt_reg;

    logic             m_valid_reg, m_ev_reg, m_intr_reg, m_prev_reg;
    kevq_entry_t      m_entry_reg;
    logic [CNT_W-1:0] m_cnt_reg;

    logic             in_acc, s1_adv, s1_clear;
    logic             pop_hit, ram_we, intr_ans, prev_cap;
    logic             is_esc, full;
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_addr;
    logic [31:0]      poll_diff;
    kevq_entry_t      new_entry, rd_entry, pop_entry;
    logic [ENTRY_W-1:0] rd_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_key_reg   <= RST_ESCAPE;
            enter_key_reg <= RST_ENTER;
            bs_key_reg    <= RST_BACKSPACE;
            tab_key_reg   <= RST_TAB;
            del_key_reg   <= RST_DELETE;
            poll_int_reg  <= RST_POLL_INT;
            fq_reg        <= RST_FORCE_QT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ESCAPE:    esc_key_reg   <= cfg_data[7:0];
                REG_ENTER:     enter_key_reg <= cfg_data[7:0];
                REG_BACKSPACE: bs_key_reg    <= cfg_data[7:0];
                REG_TAB:       tab_key_reg   <= cfg_data[7:0];
                REG_DELETE:    del_key_reg   <= cfg_data[7:0];
                REG_POLL_INT:  poll_int_reg  <= cfg_data;
                REG_FORCE_QT:  fq_reg        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign in_acc  = s_valid && s_ready;

    assign rd_entry = kevq_entry_t'(rd_bits);
    assign s1_clear = s1_valid_reg && s1_pop_reg && (rd_entry.code == esc_key_reg);
    assign uc_eff   = s1_clear ? 8'd0 : uc_reg;

    assign rp_inc    = (rp_reg == LAST_PTR) ? '0 : rp_reg + PTR_W'(1);
    assign full      = (cnt_reg == DEPTH_CNT);
    assign wr_sum    = SUM_W'(rp_reg) + SUM_W'(cnt_reg);
    assign wr_addr   = full ? rp_reg :
                       (wr_sum >= DEPTH_SUM) ? PTR_W'(wr_sum - DEPTH_SUM) : PTR_W'(wr_sum);
    assign is_esc    = (s_key_code == esc_key_reg);
    assign poll_diff = s_now_ms - last_reg;

    always_comb begin
        new_entry.code  = s_key_code;
        new_entry.shift = s_shift;
        new_entry.ctrl  = s_ctrl;
        new_entry.alt   = s_alt;
        if (s_key_code == enter_key_reg) begin
            new_entry.ch = CHAR_CR;
        end else if (s_key_code == bs_key_reg) begin
            new_entry.ch = CHAR_BS;
        end else if (s_key_code == tab_key_reg) begin
            new_entry.ch = CHAR_TAB;
        end else if (s_key_code == del_key_reg) begin
            new_entry.ch = CHAR_DEL;
        end else begin
            new_entry.ch = s_key_char;
        end
    end

    always_comb begin
        rp_next       = rp_reg;
        cnt_next      = cnt_reg;
        esc_seen_next = esc_seen_reg;
        cap_next      = cap_reg;
        uc_next       = uc_eff;
        run_next      = run_reg;
        intr_next     = intr_reg;
        last_next     = last_reg;
        pop_hit       = 1'b0;
        ram_we        = 1'b0;
        intr_ans      = 1'b0;
        prev_cap      = 1'b0;
        if (in_acc) begin
            unique case (s_command)
                CMD_KEY: begin
                    if (s_pressed) begin
                        if (is_esc && !cap_reg) begin
                            esc_seen_next = 1'b1;
                        end else begin
                            if (is_esc && uc_eff != ESC_COUNT_MAX) begin
                                uc_next = uc_eff + 8'd1;
                            end
                            ram_we = 1'b1;
                            if (full) begin
                                rp_next = rp_inc;
                            end else begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                CMD_POP: begin
                    if (cnt_reg != '0) begin
                        pop_hit  = 1'b1;
                        rp_next  = rp_inc;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                CMD_CAP: begin
                    prev_cap = cap_reg;
                    cap_next = s_capture_on;
                    if (!s_capture_on) begin
                        uc_next = 8'd0;
                    end
                end
                CMD_POLL: begin
                    if (run_reg) begin
                        if (!intr_reg && poll_diff >= {16'd0, poll_int_reg}) begin
                            last_next = s_now_ms;
                            if (esc_seen_reg || uc_eff >= fq_reg) begin
                                intr_next = 1'b1;
                            end
                        end
                        intr_ans = intr_next;
                    end
                end
                CMD_BEGIN: begin
                    intr_next     = 1'b0;
                    last_next     = s_now_ms;
                    cap_next      = 1'b0;
                    uc_next       = 8'd0;
                    esc_seen_next = 1'b0;
                    rp_next       = '0;
                    cnt_next      = '0;
                    run_next      = 1'b1;
                end
                CMD_END: begin
                    run_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    kevq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (new_entry),
        .re    (pop_hit),
        .raddr (rp_reg),
        .rdata (rd_bits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg       <= '0;
            cnt_reg      <= '0;
            esc_seen_reg <= 1'b0;
            cap_reg      <= 1'b0;
            uc_reg       <= 8'd0;
            run_reg      <= 1'b0;
            intr_reg     <= 1'b0;
            last_reg     <= 32'd0;
        end else begin
            rp_reg       <= rp_next;
            cnt_reg      <= cnt_next;
            esc_seen_reg <= esc_seen_next;
            cap_reg      <= cap_next;
            uc_reg       <= uc_next;
            run_reg      <= run_next;
            intr_reg     <= intr_next;
            last_reg     <= last_next;
        end
    end

    // hold the beat in stage one until the output register frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_pop_reg  <= pop_hit;
            s1_intr_reg <= intr_ans;
            s1_prev_reg <= prev_cap;
            s1_cnt_reg  <= cnt_next;
        end
    end

    always_comb begin
        pop_entry = rd_entry;
        if (!s1_pop_reg) begin
            pop_entry = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_adv) begin
            m_ev_reg    <= s1_pop_reg;
            m_entry_reg <= pop_entry;
            m_intr_reg  <= s1_intr_reg;
            m_prev_reg  <= s1_prev_reg;
            m_cnt_reg   <= s1_cnt_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_valid      = m_ev_reg;
    assign m_out_code         = m_entry_reg.code;
    assign m_out_char         = m_entry_reg.ch;
    assign m_out_shift        = m_entry_reg.shift;
    assign m_out_ctrl         = m_entry_reg.ctrl;
    assign m_out_alt          = m_entry_reg.alt;
    assign m_interrupt        = m_intr_reg;
    assign m_previous_capture = m_prev_reg;
    assign m_queued_count     = m_cnt_reg;

    `KEVQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= DEPTH_CNT)
    `KEVQ_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !s1_adv, s1_valid_reg)
    `KEVQ_ASSERT_NEXT(a_s1_to_out, aclk, aresetn, s1_valid_reg && s1_adv, m_valid_reg)
    `KEVQ_ASSERT_SAME(a_irq, aclk, aresetn, $rose(intr_reg), $past(in_acc && s_command == CMD_POLL))
    `KEVQ_ASSERT_SAME(a_pop_nonempty, aclk, aresetn, pop_hit, cnt_reg != '0 && !ram_we)

endmodule
